@@ rtl/core/scr_pkg.sv @@
`timescale 1ns / 1ps

package scr_pkg;

  localparam int unsigned CacheEntriesDef = 64;
  localparam int unsigned SectorBitsDef   = 32;

  localparam int unsigned FuncW    = 2;
  localparam int unsigned SectorW  = 32;
  localparam int unsigned SlotW    = 6;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_FILL   = 2'd1,
    FUNC_MARK   = 2'd2
  } func_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic scan;
    logic mark;
    logic touch;
    logic fill_free;
    logic sweep_rd;
    logic sweep;
    logic load_res;
    logic load_wb;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    func_e func;
    logic  count_zero;
    logic  full;
    logic  match;
    logic  scan_end;
    logic  hit;
    logic  hand_used;
    logic  wb_none;
    logic  wb_last;
    logic  out_free;
  } sts_t;

endpackage

@@ rtl/core/scr_ctrl.sv @@
`timescale 1ns / 1ps

module scr_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [scr_pkg::FuncW-1:0] in_func_i,
  output logic                     in_ready_o,
  input  scr_pkg::sts_t            sts_i,
  output scr_pkg::cmd_t            cmd_o
);
  import scr_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SCAN   = 8'b0000_0010,
    ST_ACT    = 8'b0000_0100,
    ST_SW_RD  = 8'b0000_1000,
    ST_SW_EV  = 8'b0001_0000,
    ST_DR_RD  = 8'b0010_0000,
    ST_DR_OUT = 8'b0100_0000,
    ST_RES    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (func_e'(in_func_i)) inside
            FUNC_LOOKUP, FUNC_FILL, FUNC_MARK: begin
              state_d = sts_i.count_zero ? ST_ACT : ST_SCAN;
            end
            default: state_d = ST_RES;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.match || sts_i.scan_end) begin
          state_d = ST_ACT;
        end
      end
      ST_ACT: begin
        unique case (sts_i.func)
          FUNC_MARK: begin
            cmd_o.mark = sts_i.hit;
            state_d    = ST_RES;
          end
          FUNC_FILL: begin
            if (sts_i.hit) begin
              cmd_o.touch = 1'b1;
              state_d     = ST_RES;
            end else if (!sts_i.full) begin
              cmd_o.fill_free = 1'b1;
              state_d         = ST_RES;
            end else begin
              state_d = ST_SW_RD;
            end
          end
          default: state_d = ST_RES;
        endcase
      end
      ST_SW_RD: begin
        cmd_o.sweep_rd = 1'b1;
        state_d        = ST_SW_EV;
      end
      ST_SW_EV: begin
        cmd_o.sweep = 1'b1;
        // an unused entry under the hand ends the sweep
        if (!sts_i.hand_used) begin
          state_d = sts_i.wb_none ? ST_RES : ST_DR_RD;
        end
      end
      ST_DR_RD: begin
        state_d = ST_DR_OUT;
      end
      ST_DR_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_wb = 1'b1;
          state_d       = sts_i.wb_last ? ST_IDLE : ST_DR_RD;
        end
      end
      ST_RES: begin
        if (sts_i.out_free) begin
          cmd_o.load_res = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/scr_dpath.sv @@
`timescale 1ns / 1ps

module scr_dpath #(
  parameter int unsigned CACHE_ENTRIES = scr_pkg::CacheEntriesDef,
  parameter int unsigned SECTOR_BITS   = scr_pkg::SectorBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [scr_pkg::SectorW-1:0] in_sector_i,
  input  logic [scr_pkg::FuncW-1:0]   in_func_i,
  input  scr_pkg::cmd_t              cmd_i,
  output scr_pkg::sts_t              sts_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic                       out_hit_o,
  output logic [scr_pkg::SlotW-1:0]   out_slot_o,
  output logic                       out_wb_o,
  output logic [scr_pkg::SectorW-1:0] out_wb_sector_o,
  output logic [scr_pkg::SlotW-1:0]   out_wb_slot_o,
  output logic                       out_last_o
);
  import scr_pkg::*;

  localparam int unsigned IdxW = $clog2(CACHE_ENTRIES);
  localparam int unsigned CntW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CACHE_ENTRIES - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(CACHE_ENTRIES);

  typedef struct packed {
    logic [SECTOR_BITS-1:0] sector;
    logic [IdxW-1:0]        slot;
  } wb_rec_t;

  // request registers
  logic [SECTOR_BITS-1:0] sec_q;
  func_e                  func_q;
  logic                   hit_q;
  logic [IdxW-1:0]        slot_q;
  logic [IdxW-1:0]        cmp_idx_q;

  // policy state
  logic [CntW-1:0]          count_q;
  logic [IdxW-1:0]          hand_q;
  logic [CACHE_ENTRIES-1:0] used_q, used_d;
  logic [CACHE_ENTRIES-1:0] dirty_q, dirty_d;

  // tag memory
  logic [SECTOR_BITS-1:0] sect_mem [CACHE_ENTRIES];
  logic [SECTOR_BITS-1:0] sect_rd_q;
  logic [IdxW-1:0]        raddr;
  logic                   sect_we;
  logic [IdxW-1:0]        sect_waddr;

  // write-back queue, filled by a sweep and drained afterwards
  wb_rec_t         wb_mem [CACHE_ENTRIES];
  wb_rec_t         wb_rd_q;
  logic [CntW-1:0] wcnt_q;
  logic [IdxW-1:0] rptr_q;

  // output register
  logic                   out_valid_q;
  logic                   out_hit_q;
  logic [IdxW-1:0]        out_slot_q;
  logic                   out_wb_q;
  logic [SECTOR_BITS-1:0] out_wb_sector_q;
  logic [IdxW-1:0]        out_wb_slot_q;
  logic                   out_last_q;

  logic [IdxW-1:0] hand_nxt;
  logic [IdxW-1:0] scan_nxt;
  logic [IdxW-1:0] free_idx;
  logic            hand_used;
  logic            hand_dirty;
  logic            wb_last;
  logic            install_sweep;

  assign hand_nxt      = (hand_q == LastIdx) ? '0 : hand_q + 1'b1;
  assign scan_nxt      = cmp_idx_q + 1'b1;
  assign free_idx      = count_q[IdxW-1:0];
  assign hand_used     = used_q[hand_q];
  assign hand_dirty    = dirty_q[hand_q];
  assign wb_last       = (CntW'(rptr_q) + CntW'(1)) == wcnt_q;
  assign install_sweep = cmd_i.sweep && !hand_used;

  always_comb begin
    raddr = '0;
    if (cmd_i.scan) begin
      raddr = scan_nxt;
    end else if (cmd_i.sweep_rd) begin
      raddr = hand_q;
    end else if (cmd_i.sweep) begin
      raddr = hand_nxt;
    end
  end

  assign sect_we    = cmd_i.fill_free || install_sweep;
  assign sect_waddr = cmd_i.fill_free ? free_idx : hand_q;

  always_comb begin
    sts_o            = '0;
    sts_o.func       = func_q;
    sts_o.count_zero = (count_q == '0);
    sts_o.full       = (count_q == FullCnt);
    sts_o.match      = (sect_rd_q == sec_q);
    sts_o.scan_end   = (CntW'(cmp_idx_q) + CntW'(1)) == count_q;
    sts_o.hit        = hit_q;
    sts_o.hand_used  = hand_used;
    sts_o.wb_none    = (wcnt_q == '0) && !hand_dirty;
    sts_o.wb_last    = wb_last;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    used_d  = used_q;
    dirty_d = dirty_q;
    if (cmd_i.mark) begin
      used_d[slot_q]  = 1'b1;
      dirty_d[slot_q] = 1'b1;
    end
    if (cmd_i.touch) begin
      used_d[slot_q] = 1'b1;
    end
    if (cmd_i.fill_free) begin
      used_d[free_idx]  = 1'b1;
      dirty_d[free_idx] = 1'b0;
    end
    if (cmd_i.sweep) begin
      // second chance clears a used bit; an unused entry is replaced and marked used
      used_d[hand_q]  = !hand_used;
      dirty_d[hand_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      hand_q      <= '0;
      used_q      <= '0;
      dirty_q     <= '0;
      wcnt_q      <= '0;
      rptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_q  <= used_d;
      dirty_q <= dirty_d;
      if (cmd_i.fill_free) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.sweep) begin
        hand_q <= hand_nxt;
      end
      if (cmd_i.capture) begin
        wcnt_q <= '0;
      end else if (cmd_i.sweep && hand_dirty) begin
        wcnt_q <= wcnt_q + CntW'(1);
      end
      if (cmd_i.capture) begin
        rptr_q <= '0;
      end else if (cmd_i.load_wb) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (cmd_i.load_res || cmd_i.load_wb) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sec_q     <= in_sector_i[SECTOR_BITS-1:0];
      func_q    <= func_e'(in_func_i);
      hit_q     <= 1'b0;
      slot_q    <= '0;
      cmp_idx_q <= '0;
    end
    if (cmd_i.scan) begin
      if (sts_o.match) begin
        hit_q  <= 1'b1;
        slot_q <= cmp_idx_q;
      end else begin
        cmp_idx_q <= scan_nxt;
      end
    end
    if (cmd_i.fill_free) begin
      slot_q <= free_idx;
    end
    if (install_sweep) begin
      slot_q <= hand_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sect_we) begin
      sect_mem[sect_waddr] <= sec_q;
    end
    sect_rd_q <= sect_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep && hand_dirty) begin
      wb_mem[wcnt_q[IdxW-1:0]] <= '{sector: sect_rd_q, slot: hand_q};
    end
    wb_rd_q <= wb_mem[rptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      out_hit_q       <= hit_q;
      out_slot_q      <= slot_q;
      out_wb_q        <= 1'b0;
      out_wb_sector_q <= '0;
      out_wb_slot_q   <= '0;
      out_last_q      <= 1'b1;
    end else if (cmd_i.load_wb) begin
      out_hit_q       <= 1'b0;
      out_slot_q      <= slot_q;
      out_wb_q        <= 1'b1;
      out_wb_sector_q <= wb_rd_q.sector;
      out_wb_slot_q   <= wb_rd_q.slot;
      out_last_q      <= wb_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_hit_o       = out_hit_q;
  assign out_slot_o      = SlotW'(out_slot_q);
  assign out_wb_o        = out_wb_q;
  assign out_wb_sector_o = SectorW'(out_wb_sector_q);
  assign out_wb_slot_o   = SlotW'(out_wb_slot_q);
  assign out_last_o      = out_last_q;

endmodule

@@ rtl/core/sector_cache_clock_replacement.sv @@
`timescale 1ns / 1ps

// tag and replacement store of a fully associative sector cache, clock policy
// input beat: tuser = request kind (lookup, fill, mark written), tdata = sector
// output beats: one per request, except a fill into a full cache that passes
// dirty entries: one beat per write-back, all carrying the replaced slot, and
// tlast on the final beat of the request
// a request to a non-empty cache walks the tag memory one slot per cycle from
// slot 0 until it matches or reaches the last resident entry; the next
// request is taken once the result is loaded into the output register
// a fill into a full cache then reads the tag under the hand, sweeps the hand
// one slot per cycle, at most CACHE_ENTRIES+1 steps, and drains the
// write-backs, reading each from the queue before it is loaded as a beat
// one request is in work at a time; tready is high only between requests
// the last result sits in an output register, so the next request is taken
// while it waits; a stalled receiver holds the sweep drain and the result
// reset empties the cache, clears all used and dirty bits and parks the hand
// at slot 0; no pass over the tag memory is needed
module sector_cache_clock_replacement #(
  parameter int unsigned CACHE_ENTRIES = scr_pkg::CacheEntriesDef,
  parameter int unsigned SECTOR_BITS   = scr_pkg::SectorBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [scr_pkg::SectorW-1:0]  s_axis_tdata,  // sector
  input  logic [scr_pkg::FuncW-1:0]    s_axis_tuser,  // func
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // hit, slot, writeback_sector, writeback_slot, zero pad
  output logic [scr_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [0:0]                  m_axis_tuser,  // writeback
  output logic                        m_axis_tlast
);
  import scr_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic               out_hit;
  logic [SlotW-1:0]   out_slot;
  logic               out_wb;
  logic [SectorW-1:0] out_wb_sector;
  logic [SlotW-1:0]   out_wb_slot;

  scr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scr_dpath #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .SECTOR_BITS   (SECTOR_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_sector_i     (s_axis_tdata),
    .in_func_i       (s_axis_tuser),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_hit_o       (out_hit),
    .out_slot_o      (out_slot),
    .out_wb_o        (out_wb),
    .out_wb_sector_o (out_wb_sector),
    .out_wb_slot_o   (out_wb_slot),
    .out_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_wb_slot, out_wb_sector, out_slot, out_hit};
  assign m_axis_tuser = out_wb;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while the previous one is in work");

  a_wb_never_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[0])
    else $error("write-back beat reports a hit");

  a_plain_wb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[44:7] == '0 && m_axis_tlast)
    else $error("plain result carries write-back fields or is not final");
`endif

endmodule
